// ===== rtl/omre_pkg.sv =====
// Types and constants shared by the ordered multiset rank engine.
package omre_pkg;

    localparam logic signed [31:0] NONE_BELOW = 32'sh8000_0001;
    localparam logic signed [31:0] NONE_ABOVE = 32'sh7FFF_FFFF;
    localparam logic [15:0]        TOTAL_MAX  = 16'hFFFF;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_FULL  = 2'd1;
    localparam logic [1:0] STS_RANGE = 2'd2;

    typedef enum logic [2:0] {
        REQ_INSERT = 3'd0,
        REQ_DELETE = 3'd1,
        REQ_RANK   = 3'd2,
        REQ_KTH    = 3'd3,
        REQ_PRED   = 3'd4,
        REQ_SUCC   = 3'd5
    } t_req_type;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT_UP,
        ST_SHIFT_DN,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] key_value;
        logic [15:0]        rank_index;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [16:0]        result_rank;
        logic [1:0]         status;
    } t_out_item;

endpackage

// ===== rtl/ordered_multiset_rank_engine.sv =====
// Ordered multiset of signed keys with insert, delete, rank, kth, predecessor, successor.
//
// Distinct keys are kept in ascending order in one memory, each with a copy count.
// Every request but an unknown one or an out-of-range kth makes one pass over the table
// through a single registered read port, one entry per cycle: the search stops at the
// first entry not below the key (above it, for successor; for kth, where the running copy
// count reaches the index), and an insert of a new key or a delete of a last copy
// continues the same pass, moving the later entries up or down one slot per cycle. A kth
// request out of range and an unknown request skip the pass and go straight to the
// result. The input is ready only between requests; one result may wait in the output
// register while the next request runs. No clearing pass is needed after reset.
module ordered_multiset_rank_engine #(
    parameter int DISTINCT_DEPTH  = 1024,
    parameter int COPY_COUNT_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  omre_pkg::t_in_item   i_in_req,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output omre_pkg::t_out_item  o_out_res
);
    import omre_pkg::*;

    localparam int CCB = COPY_COUNT_BITS;
    localparam int EW  = 32 + CCB;
    localparam int AW  = $clog2(DISTINCT_DEPTH);
    localparam int UW  = $clog2(DISTINCT_DEPTH + 1);
    localparam int IW  = UW + 1;
    localparam logic [UW-1:0] DEPTH_U = UW'(DISTINCT_DEPTH);

    logic [EW-1:0]      mem [DISTINCT_DEPTH];

    t_state             r_state, n_state;
    t_in_item           r_req, n_req;
    logic [UW-1:0]      r_used, n_used;
    logic [15:0]        r_total, n_total;
    logic [16:0]        r_acc, n_acc;
    logic signed [31:0] r_prev, n_prev;
    logic               r_have_prev, n_have_prev;
    logic [EW-1:0]      r_hold, n_hold;
    t_out_item          r_res, n_res;
    logic [IW-1:0]      r_issue;
    logic [IW-1:0]      r_ridx;
    logic [EW-1:0]      r_rdata;
    logic               r_rv;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               w_en;
    logic [AW-1:0]      w_addr;
    logic [EW-1:0]      w_data;

    logic               accept, out_free, scanning, n_scanning;
    logic signed [31:0] d_key, q_key;
    logic [CCB-1:0]     d_cnt;
    logic [32:0]        cnt_wide;
    logic [16:0]        acc_sum;
    logic [IW-1:0]      ridx_dn;
    logic               in_tab, key_eq, stop, hit, ins_refuse, kth_bad;
    logic               shift_up_go, shift_dn_go;

    assign accept      = i_in_valid && (r_state == ST_IDLE);
    assign o_in_ready  = (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;
    assign scanning    = (r_state == ST_SEARCH) || (r_state == ST_SHIFT_UP) ||
                         (r_state == ST_SHIFT_DN);
    assign n_scanning  = (n_state == ST_SEARCH) || (n_state == ST_SHIFT_UP) ||
                         (n_state == ST_SHIFT_DN);

    always_comb begin
        d_key       = r_rdata[EW-1 -: 32];
        d_cnt       = r_rdata[CCB-1:0];
        q_key       = r_req.key_value;
        cnt_wide    = {{(33 - CCB){1'b0}}, d_cnt};
        acc_sum     = r_acc + cnt_wide[16:0];
        ridx_dn     = r_ridx - 1'b1;
        in_tab      = r_ridx < {1'b0, r_used};
        key_eq      = d_key == q_key;
        kth_bad     = (i_in_req.rank_index == 16'd0) || (i_in_req.rank_index > r_total);
        unique case (r_req.req_type)
            REQ_KTH:  stop = !in_tab || (acc_sum >= {1'b0, r_req.rank_index});
            REQ_SUCC: stop = !in_tab || (d_key > q_key);
            default:  stop = !in_tab || (d_key >= q_key);
        endcase
        hit         = in_tab && key_eq;
        if (hit) begin
            ins_refuse = (d_cnt == {CCB{1'b1}}) || (r_total == TOTAL_MAX);
        end else begin
            ins_refuse = (r_used == DEPTH_U) || (r_total == TOTAL_MAX);
        end
        shift_up_go = (r_req.req_type == REQ_INSERT) && !hit && !ins_refuse && in_tab;
        shift_dn_go = (r_req.req_type == REQ_DELETE) && hit && (d_cnt == CCB'(1));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_in_req.req_type > REQ_SUCC ||
                        (i_in_req.req_type == REQ_KTH && kth_bad)) begin
                        n_state = ST_RESULT;
                    end else begin
                        n_state = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (r_rv && stop) begin
                    priority if (shift_up_go) begin
                        n_state = ST_SHIFT_UP;
                    end else if (shift_dn_go) begin
                        n_state = ST_SHIFT_DN;
                    end else begin
                        n_state = ST_RESULT;
                    end
                end
            end
            ST_SHIFT_UP, ST_SHIFT_DN: begin
                if (r_rv && !in_tab) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_req       = r_req;
        n_used      = r_used;
        n_total     = r_total;
        n_acc       = r_acc;
        n_prev      = r_prev;
        n_have_prev = r_have_prev;
        n_hold      = r_hold;
        n_res       = r_res;
        w_en        = 1'b0;
        w_addr      = r_ridx[AW-1:0];
        w_data      = r_rdata;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_req       = i_in_req;
                    n_acc       = '0;
                    n_have_prev = 1'b0;
                    n_res       = '0;
                    if (i_in_req.req_type == REQ_KTH && kth_bad) begin
                        n_res.status = STS_RANGE;
                    end
                end
            end
            ST_SEARCH: begin
                if (r_rv && !stop) begin
                    n_acc       = acc_sum;
                    n_prev      = d_key;
                    n_have_prev = 1'b1;
                end else if (r_rv) begin
                    unique case (r_req.req_type)
                        REQ_INSERT: begin
                            if (ins_refuse) begin
                                n_res.status = STS_FULL;
                            end else if (hit) begin
                                w_en    = 1'b1;
                                w_data  = {q_key, d_cnt + CCB'(1)};
                                n_total = r_total + 16'd1;
                            end else begin
                                w_en    = 1'b1;
                                w_data  = {q_key, CCB'(1)};
                                n_total = r_total + 16'd1;
                                n_hold  = r_rdata;
                                if (!in_tab) begin
                                    n_used = r_used + 1'b1;
                                end
                            end
                        end
                        REQ_DELETE: begin
                            if (hit && d_cnt != '0) begin
                                if (r_total != 16'd0) begin
                                    n_total = r_total - 16'd1;
                                end
                                if (d_cnt != CCB'(1)) begin
                                    w_en   = 1'b1;
                                    w_data = {d_key, d_cnt - CCB'(1)};
                                end
                            end
                        end
                        REQ_RANK: begin
                            n_res.result_rank = r_acc + 17'd1;
                        end
                        REQ_KTH: begin
                            if (in_tab) begin
                                n_res.result_value = d_key;
                            end else begin
                                n_res.status = STS_RANGE;
                            end
                        end
                        REQ_PRED: begin
                            n_res.result_value = r_have_prev ? r_prev : NONE_BELOW;
                        end
                        REQ_SUCC: begin
                            n_res.result_value = in_tab ? d_key : NONE_ABOVE;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SHIFT_UP: begin
                if (r_rv) begin
                    w_en   = 1'b1;
                    w_data = r_hold;
                    n_hold = r_rdata;
                    if (!in_tab) begin
                        n_used = r_used + 1'b1;
                    end
                end
            end
            ST_SHIFT_DN: begin
                if (r_rv) begin
                    if (in_tab) begin
                        w_en   = 1'b1;
                        w_addr = ridx_dn[AW-1:0];
                    end else begin
                        n_used = r_used - 1'b1;
                    end
                end
            end
            ST_RESULT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        r_rdata <= mem[r_issue[AW-1:0]];
        r_ridx  <= r_issue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_total     <= '0;
            r_rv        <= 1'b0;
            r_issue     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_total <= n_total;
            r_rv    <= scanning && n_scanning;
            r_issue <= scanning ? r_issue + 1'b1 : '0;
            if (r_state == ST_RESULT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_acc       <= n_acc;
        r_prev      <= n_prev;
        r_have_prev <= n_have_prev;
        r_hold      <= n_hold;
        r_res       <= n_res;
        if (r_state == ST_RESULT && out_free) begin
            r_out <= r_res;
        end
    end

endmodule

// ===== tb/omre_checker.sv =====
// Checker for the ordered multiset rank engine: tracks the stored multiset and compares results.
`timescale 1ns / 1ps

module omre_checker #(
    parameter int DISTINCT_DEPTH  = 1024,
    parameter int COPY_COUNT_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  logic                i_req_ready,
    input  omre_pkg::t_in_item  i_req,
    input  logic                i_res_valid,
    input  logic                i_res_ready,
    input  omre_pkg::t_out_item i_res,
    output int                  o_failures,
    output int                  o_outstanding
);
    import omre_pkg::*;

    localparam longint COPY_MAX = (longint'(1) << COPY_COUNT_BITS) - 1;

    logic signed [31:0] set_key    [DISTINCT_DEPTH];
    longint             set_copies [DISTINCT_DEPTH];
    int                 distinct_cnt = 0;
    int                 total_cnt    = 0;
    t_out_item          pending_results[$];
    int                 failures     = 0;

    function automatic int first_not_below(input logic signed [31:0] probe);
        int pos = 0;
        while (pos < distinct_cnt && set_key[pos] < probe) pos++;
        return pos;
    endfunction

    function automatic t_out_item apply_request(input t_in_item req);
        t_out_item          res;
        logic signed [31:0] probe;
        int                 pos;
        logic               found;
        longint             acc;
        res   = '0;
        probe = req.key_value;
        pos   = first_not_below(probe);
        found = (pos < distinct_cnt) && (set_key[pos] == probe);
        acc   = 0;
        case (req.req_type)
            REQ_INSERT: begin
                if (found) begin
                    if (set_copies[pos] >= COPY_MAX || total_cnt >= TOTAL_MAX) begin
                        res.status = STS_FULL;
                    end else begin
                        set_copies[pos]++;
                        total_cnt++;
                    end
                end else if (distinct_cnt >= DISTINCT_DEPTH || total_cnt >= TOTAL_MAX) begin
                    res.status = STS_FULL;
                end else begin
                    for (int i = distinct_cnt; i > pos; i--) begin
                        set_key[i]    = set_key[i-1];
                        set_copies[i] = set_copies[i-1];
                    end
                    set_key[pos]    = probe;
                    set_copies[pos] = 1;
                    distinct_cnt++;
                    total_cnt++;
                end
            end
            REQ_DELETE: begin
                if (found && set_copies[pos] > 0) begin
                    set_copies[pos]--;
                    if (total_cnt > 0) total_cnt--;
                    if (set_copies[pos] == 0) begin
                        for (int i = pos; i + 1 < distinct_cnt; i++) begin
                            set_key[i]    = set_key[i+1];
                            set_copies[i] = set_copies[i+1];
                        end
                        distinct_cnt--;
                    end
                end
            end
            REQ_RANK: begin
                for (int i = 0; i < pos; i++) acc += set_copies[i];
                res.result_rank = 17'(acc + 1);
            end
            REQ_KTH: begin
                res.status = STS_RANGE;
                if (req.rank_index != 0 && req.rank_index <= total_cnt) begin
                    for (int i = 0; i < distinct_cnt; i++) begin
                        acc += set_copies[i];
                        if (acc >= req.rank_index) begin
                            res.result_value = set_key[i];
                            res.status       = STS_OK;
                            break;
                        end
                    end
                end
            end
            REQ_PRED: begin
                res.result_value = (pos > 0) ? set_key[pos-1] : NONE_BELOW;
            end
            REQ_SUCC: begin
                if (found) pos++;
                res.result_value = (pos < distinct_cnt) ? set_key[pos] : NONE_ABOVE;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            distinct_cnt = 0;
            total_cnt    = 0;
            pending_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result: value %0d, rank %0d, status %0d",
                           $signed(i_res.result_value), i_res.result_rank, i_res.status);
                    failures++;
                end else begin
                    want = pending_results.pop_front();
                    if (i_res.result_value !== want.result_value) begin
                        $error("result_value: expected %0d, got %0d",
                               $signed(want.result_value), $signed(i_res.result_value));
                        failures++;
                    end
                    if (i_res.result_rank !== want.result_rank) begin
                        $error("result_rank: expected %0d, got %0d",
                               want.result_rank, i_res.result_rank);
                        failures++;
                    end
                    if (i_res.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_res.status);
                        failures++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) pending_results.push_back(apply_request(i_req));
        end
        o_failures    <= failures;
        o_outstanding <= pending_results.size();
    end

endmodule

// ===== tb/ordered_multiset_rank_engine_test.sv =====
// Testbench top for the ordered multiset rank engine: clock, reset, requests and verdict.
`timescale 1ns / 1ps

module ordered_multiset_rank_engine_test;
    import omre_pkg::*;

    localparam int DEPTH          = 1024;
    localparam int COUNT_BITS     = 16;
    localparam int QUIET_LIMIT    = 8000;
    localparam int DRAIN_CYCLES   = 1100;
    localparam int CHUNK_COUNT    = 7;
    localparam int CHUNK_REQUESTS = 48;
    localparam int FILL_COUNT     = 208;

    localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
    localparam logic [2:0] REQ_UNUSED_7 = 3'd7;

    localparam logic signed [31:0] KEY_MIN   = 32'sh8000_0000;
    localparam logic signed [31:0] FILL_BASE = 32'sh1000_0000;
    localparam logic signed [31:0] FILL_PAST = 32'sh2000_0000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    t_in_item  req_item  = '0;
    logic      res_valid;
    logic      res_ready = 1'b1;
    t_out_item res_item;
    int        failures;
    int        outstanding;
    logic      idle_on   = 1'b1;
    int        quiet_cycles = 0;

    ordered_multiset_rank_engine #(
        .DISTINCT_DEPTH (DEPTH),
        .COPY_COUNT_BITS(COUNT_BITS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (req_valid),
        .o_in_ready (req_ready),
        .i_in_req   (req_item),
        .o_out_valid(res_valid),
        .i_out_ready(res_ready),
        .o_out_res  (res_item)
    );

    omre_checker #(
        .DISTINCT_DEPTH (DEPTH),
        .COPY_COUNT_BITS(COUNT_BITS)
    ) checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_ready  (req_ready),
        .i_req        (req_item),
        .i_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .i_res        (res_item),
        .o_failures   (failures),
        .o_outstanding(outstanding)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    task automatic issue(input logic [2:0] kind, input logic signed [31:0] key,
                         input logic [15:0] idx);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        req_item  <= '{req_type: kind, key_value: key, rank_index: idx};
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
    endtask

    function automatic logic signed [31:0] random_key();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $signed(32'($urandom_range(0, 15))) - 32'sd8;
            6: begin
                case ($urandom_range(0, 4))
                    0: return KEY_MIN;
                    1: return NONE_BELOW;
                    2: return NONE_ABOVE;
                    3: return -32'sd1;
                    default: return 32'sd0;
                endcase
            end
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic logic [15:0] random_index();
        if ($urandom_range(0, 4) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 48));
    endfunction

    function automatic logic [2:0] random_kind();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30) return REQ_INSERT;
        if (roll < 55) return REQ_DELETE;
        if (roll < 67) return REQ_RANK;
        if (roll < 79) return REQ_KTH;
        if (roll < 89) return REQ_PRED;
        if (roll < 97) return REQ_SUCC;
        if (roll < 98) return REQ_UNUSED_6;
        return REQ_UNUSED_7;
    endfunction

    // hold ready low in random bursts while idling is on
    initial begin
        forever begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                res_ready <= 1'b1;
            end
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge clk);
            if ((req_valid && req_ready) || (res_valid && res_ready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("ordered_multiset_rank_engine test failed");
        $finish;
    end

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // empty store
        issue(REQ_KTH,    $signed($urandom), 16'd1);
        issue(REQ_PRED,   32'sd0,            16'($urandom));
        issue(REQ_SUCC,   32'sd0,            16'($urandom));
        issue(REQ_RANK,   NONE_ABOVE,        16'($urandom));
        issue(REQ_DELETE, 32'sd7,            16'($urandom));
        // extremes and duplicates
        issue(REQ_INSERT, KEY_MIN,           16'($urandom));
        issue(REQ_INSERT, NONE_ABOVE,        16'($urandom));
        issue(REQ_INSERT, NONE_BELOW,        16'($urandom));
        issue(REQ_INSERT, 32'sd0,            16'($urandom));
        issue(REQ_INSERT, 32'sd0,            16'($urandom));
        issue(REQ_INSERT, 32'sd5,            16'($urandom));
        issue(REQ_RANK,   32'sd0,            16'($urandom));
        issue(REQ_RANK,   KEY_MIN,           16'($urandom));
        issue(REQ_KTH,    $signed($urandom), 16'd0);
        issue(REQ_KTH,    $signed($urandom), 16'd6);
        issue(REQ_KTH,    $signed($urandom), 16'd7);
        issue(REQ_KTH,    $signed($urandom), 16'hFFFF);
        issue(REQ_PRED,   KEY_MIN,           16'($urandom));
        issue(REQ_PRED,   32'sd0,            16'($urandom));
        issue(REQ_SUCC,   NONE_ABOVE,        16'($urandom));
        issue(REQ_SUCC,   32'sd0,            16'($urandom));
        issue(REQ_DELETE, 32'sd0,            16'($urandom));
        issue(REQ_DELETE, 32'sd0,            16'($urandom));
        issue(REQ_DELETE, 32'sd0,            16'($urandom));
        issue(REQ_UNUSED_6, $signed($urandom), 16'($urandom));
        issue(REQ_UNUSED_7, $signed($urandom), 16'($urandom));

        for (int chunk = 0; chunk < CHUNK_COUNT; chunk++) begin
            idle_on <= ($urandom_range(0, 3) != 0);
            for (int n = 0; n < CHUNK_REQUESTS; n++) begin
                issue(random_kind(), random_key(), random_index());
            end
        end

        // grow the table with a long ascending run, then probe around it
        idle_on <= 1'b0;
        for (int n = 0; n < FILL_COUNT; n++) begin
            issue(REQ_INSERT, FILL_BASE + 32'(n * 3), 16'($urandom));
        end
        issue(REQ_INSERT, FILL_PAST,  16'($urandom));
        issue(REQ_INSERT, FILL_BASE,  16'($urandom));
        issue(REQ_RANK,   NONE_ABOVE, 16'($urandom));
        issue(REQ_KTH,    32'sd0,     16'd1);
        issue(REQ_KTH,    32'sd0,     16'hFFFF);
        issue(REQ_PRED,   NONE_ABOVE, 16'($urandom));
        issue(REQ_SUCC,   KEY_MIN,    16'($urandom));
        issue(REQ_DELETE, FILL_BASE + 32'sd3, 16'($urandom));
        issue(REQ_INSERT, FILL_PAST,  16'($urandom));
        issue(REQ_SUCC,   FILL_BASE,  16'($urandom));
        req_valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && outstanding == 0) begin
            $display("ordered_multiset_rank_engine test passed");
        end else begin
            $display("ordered_multiset_rank_engine test failed");
        end
        $finish;
    end

endmodule
